// ----- hw/rtl/gsse_pkg.sv -----
package gsse_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned TOTAL_W   = 12;
  localparam int unsigned THRESH_W  = 9;
  localparam int unsigned ANGLE_W   = 9;
  localparam int unsigned CV_W      = 11;
  localparam int unsigned STATUS_W  = 8;
  localparam int unsigned ACODE_W   = 3;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd180;
  localparam logic [BYTE_W-1:0]   SYNC_BYTE    = 8'h55;
  localparam logic [BYTE_W-1:0]   ANGLE_TYPE   = 8'h53;

  localparam logic ACTION_FLEX = 1'b0;
  localparam logic ACTION_GYRO = 1'b1;

  localparam int unsigned TYPE_POS    = 1;
  localparam int unsigned ROLL_LO_POS = 2;
  localparam int unsigned ROLL_HI_POS = 3;
  localparam int unsigned YAW_LO_POS  = 6;
  localparam int unsigned YAW_HI_POS  = 7;

  typedef struct packed {
    logic                      valid;
    logic [TOTAL_W-1:0]        avg_index;
    logic [TOTAL_W-1:0]        avg_middle;
    logic [2*ACODE_W-1:0]      angle_bits;
  } avg_beat_t;

  function automatic logic signed [ANGLE_W-1:0] word_to_deg(input logic [BYTE_W-1:0] lo,
                                                            input logic [BYTE_W-1:0] hi);
    logic signed [15:0] word;
    logic signed [24:0] prod;
    logic signed [24:0] adj;
    word = signed'({hi, lo});
    prod = 25'(word) * 25'sd180;
    adj  = prod[24] ? prod + 25'sd32767 : prod;
    return ANGLE_W'(adj >>> 15);
  endfunction

  function automatic logic [ACODE_W-1:0] angle_code(input logic signed [ANGLE_W-1:0] ang);
    logic [ANGLE_W-1:0] mag;
    logic [1:0]         lvl;
    mag = ang[ANGLE_W-1] ? ANGLE_W'(-ang) : ANGLE_W'(ang);
    if (mag >= ANGLE_W'(30)) begin
      lvl = 2'd3;
    end else if (mag >= ANGLE_W'(20)) begin
      lvl = 2'd2;
    end else if (mag >= ANGLE_W'(10)) begin
      lvl = 2'd1;
    end else begin
      lvl = 2'd0;
    end
    return {lvl, ang[ANGLE_W-1]};
  endfunction

endpackage

// ----- hw/rtl/gsse_in_if.sv -----
interface gsse_in_if import gsse_pkg::*;;
  logic                valid;
  logic                ready;
  logic                action;
  logic [SAMPLE_W-1:0] index_sample;
  logic [SAMPLE_W-1:0] middle_sample;
  logic [BYTE_W-1:0]   rx_byte;

  modport source (output valid, output action, output index_sample, output middle_sample,
                  output rx_byte, input ready);
  modport sink (input valid, input action, input index_sample, input middle_sample,
                input rx_byte, output ready);
endinterface

// ----- hw/rtl/gsse_out_if.sv -----
interface gsse_out_if import gsse_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status_byte;

  modport source (output valid, output status_byte, input ready);
  modport sink (input valid, input status_byte, output ready);
endinterface

// ----- hw/rtl/gsse_gyro_framer.sv -----
module gsse_gyro_framer import gsse_pkg::*; #(
  parameter int unsigned PACKET_LENGTH = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic [BYTE_W-1:0]        rx_byte_i,
  output logic [2*ACODE_W-1:0]     angle_bits_o
);

  localparam int unsigned CntW = $clog2(PACKET_LENGTH);

  logic [CntW-1:0]           cnt_q;
  logic [CntW:0]             cnt_inc;
  logic                      drop;
  logic                      done;
  logic                      take;
  logic [BYTE_W-1:0]         type_q, rlo_q, rhi_q, ylo_q, yhi_q;
  logic [BYTE_W-1:0]         type_e, rlo_e, rhi_e, ylo_e, yhi_e;
  logic signed [ANGLE_W-1:0] roll_q, yaw_q;

  assign cnt_inc = {1'b0, cnt_q} + (CntW+1)'(1);
  assign drop    = (cnt_q == '0) && (rx_byte_i != SYNC_BYTE);
  assign done    = cnt_inc == (CntW+1)'(PACKET_LENGTH);
  assign take    = adv_i && !drop;

  // The byte arriving now may itself be one of the fields of a finishing packet.
  assign type_e = (cnt_q == CntW'(TYPE_POS))    ? rx_byte_i : type_q;
  assign rlo_e  = (cnt_q == CntW'(ROLL_LO_POS)) ? rx_byte_i : rlo_q;
  assign rhi_e  = (cnt_q == CntW'(ROLL_HI_POS)) ? rx_byte_i : rhi_q;
  assign ylo_e  = (cnt_q == CntW'(YAW_LO_POS))  ? rx_byte_i : ylo_q;
  assign yhi_e  = (cnt_q == CntW'(YAW_HI_POS))  ? rx_byte_i : yhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      roll_q <= '0;
      yaw_q  <= '0;
    end else if (take) begin
      cnt_q <= done ? '0 : cnt_inc[CntW-1:0];
      if (done && (type_e == ANGLE_TYPE)) begin
        roll_q <= word_to_deg(rlo_e, rhi_e);
        yaw_q  <= word_to_deg(ylo_e, yhi_e);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      type_q <= type_e;
      rlo_q  <= rlo_e;
      rhi_q  <= rhi_e;
      ylo_q  <= ylo_e;
      yhi_q  <= yhi_e;
    end
  end

  assign angle_bits_o = {angle_code(yaw_q), angle_code(roll_q)};

endmodule

// ----- hw/rtl/gsse_flex_accum.sv -----
module gsse_flex_accum import gsse_pkg::*; #(
  parameter int unsigned SAMPLES_AVERAGED = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  stage_en_i,
  input  logic [SAMPLE_W-1:0]   index_sample_i,
  input  logic [SAMPLE_W-1:0]   middle_sample_i,
  input  logic [2*ACODE_W-1:0]  angle_bits_i,
  output avg_beat_t             beat_o
);

  localparam int unsigned RecipShift = 14;
  localparam int unsigned Recip      = (2**RecipShift + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED;
  localparam int unsigned ProdW      = TOTAL_W + RecipShift + 1;

  logic [TOTAL_W-1:0] idx_total_q, mid_total_q;
  logic [TOTAL_W-1:0] idx_new, mid_new;
  logic [1:0]         cnt_q, cnt_new;
  logic               emit;
  logic [ProdW-1:0]   idx_prod, mid_prod;

  assign idx_new  = idx_total_q + TOTAL_W'(index_sample_i);
  assign mid_new  = mid_total_q + TOTAL_W'(middle_sample_i);
  assign cnt_new  = cnt_q + 2'd1;
  assign emit     = cnt_new == 2'(SAMPLES_AVERAGED);
  assign idx_prod = ProdW'(idx_new) * ProdW'(Recip);
  assign mid_prod = ProdW'(mid_new) * ProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_total_q <= '0;
      mid_total_q <= '0;
      cnt_q       <= '0;
      beat_o      <= '0;
    end else begin
      if (adv_i) begin
        idx_total_q <= emit ? '0 : idx_new;
        mid_total_q <= emit ? '0 : mid_new;
        cnt_q       <= emit ? '0 : cnt_new;
      end
      if (stage_en_i) begin
        beat_o.valid      <= adv_i && emit;
        beat_o.avg_index  <= idx_prod[TOTAL_W+RecipShift-1:RecipShift];
        beat_o.avg_middle <= mid_prod[TOTAL_W+RecipShift-1:RecipShift];
        beat_o.angle_bits <= angle_bits_i;
      end
    end
  end

endmodule

// ----- hw/rtl/gsse_click_eval.sv -----
module gsse_click_eval import gsse_pkg::*; (
  input  avg_beat_t              beat_i,
  input  logic [THRESH_W-1:0]    threshold_i,
  output logic [STATUS_W-1:0]    status_byte_o
);

  localparam int unsigned MulW = TOTAL_W + 9;

  logic [MulW-1:0] idx_mul, mid_mul;
  logic [CV_W-1:0] idx_cv, mid_cv;

  assign idx_mul = MulW'(beat_i.avg_index) * MulW'(330);
  assign mid_mul = MulW'(beat_i.avg_middle) * MulW'(330);
  assign idx_cv  = idx_mul[MulW-1:10];
  assign mid_cv  = mid_mul[MulW-1:10];

  assign status_byte_o = {beat_i.angle_bits,
                          mid_cv > CV_W'(threshold_i),
                          idx_cv > CV_W'(threshold_i)};

endmodule

// ----- hw/rtl/glove_sensor_status_encoder_core.sv -----
// Glove status encoder: one beat is accepted per cycle while input ready is high, either
// a gyro serial byte or a flex ADC pair. A status byte is produced for every third flex
// pair (SAMPLES_AVERAGED) and passes through the input register, the averaging stage
// and the result register, in that order. Input ready drops only when the input register
// holds a beat and the averaging stage and the result register both hold an untaken
// status byte, so the rate is set by the output handshake alone. The click threshold
// register may be written at any idle time.
module glove_sensor_status_encoder_core import gsse_pkg::*; #(
  parameter int unsigned PACKET_LENGTH    = 11,
  parameter int unsigned SAMPLES_AVERAGED = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [THRESH_W-1:0] cfg_wdata_i,
  gsse_in_if.sink             in_i,
  gsse_out_if.source          out_o
);

  logic [THRESH_W-1:0] thresh_q;
  logic                s1_valid_q;
  logic                s1_action_q;
  logic [SAMPLE_W-1:0] s1_index_q, s1_middle_q;
  logic [BYTE_W-1:0]   s1_rx_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                out_en, a_en, in_ready;
  logic                gyro_adv, flex_adv;
  logic [2*ACODE_W-1:0] angle_bits;
  avg_beat_t           a_beat;

  assign out_en   = !out_valid_q || out_o.ready;
  assign a_en     = !a_beat.valid || out_en;
  assign in_ready = !s1_valid_q || a_en;
  assign gyro_adv = s1_valid_q && a_en && (s1_action_q == ACTION_GYRO);
  assign flex_adv = s1_valid_q && a_en && (s1_action_q == ACTION_FLEX);

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.status_byte = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= THRESH_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_en) begin
        out_valid_q <= a_beat.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_action_q <= in_i.action;
      s1_index_q  <= in_i.index_sample;
      s1_middle_q <= in_i.middle_sample;
      s1_rx_q     <= in_i.rx_byte;
    end
    if (out_en) begin
      status_q <= status_d;
    end
  end

  gsse_gyro_framer #(
    .PACKET_LENGTH(PACKET_LENGTH)
  ) u_gyro (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (gyro_adv),
    .rx_byte_i    (s1_rx_q),
    .angle_bits_o (angle_bits)
  );

  gsse_flex_accum #(
    .SAMPLES_AVERAGED(SAMPLES_AVERAGED)
  ) u_flex (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (flex_adv),
    .stage_en_i      (a_en),
    .index_sample_i  (s1_index_q),
    .middle_sample_i (s1_middle_q),
    .angle_bits_i    (angle_bits),
    .beat_o          (a_beat)
  );

  gsse_click_eval u_click (
    .beat_i        (a_beat),
    .threshold_i   (thresh_q),
    .status_byte_o (status_d)
  );

  a_pending_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_beat.valid && out_valid_q && !out_o.ready) |=> a_beat.valid)
    else $error("Pending status beat was lost while the output stalled.");

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("Input stalled although the result register is empty.");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(a_beat.valid))
    else $error("Result beat appeared without a pending averaged beat.");

endmodule
